FILE: rtl/word_frequency_table_core_defines.svh
// Assertion macros used by the word frequency table engine.
`ifndef WORD_FREQUENCY_TABLE_CORE_DEFINES_SVH
`define WORD_FREQUENCY_TABLE_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define WFT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define WFT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define WFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wft_pkg.sv
package wft_pkg;

  // Fixed field widths of the item formats.
  localparam int LEN_W   = 4;
  localparam int IDX_OUT = 5;
  localparam int TEXT_OUT = 64;
  localparam int CNT_OUT = 16;

  // Request codes.
  localparam logic [1:0] REQ_TEXT  = 2'd0;
  localparam logic [1:0] REQ_FLUSH = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Result kinds.
  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Largest count the result field can show.
  localparam logic [31:0] CNT_FIELD_MAX = 32'h0000_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_byte;
    logic [4:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [4:0]  entry_index;
    logic [63:0] word_text;
    logic [3:0]  word_length;
    logic [15:0] word_count;
    logic        is_new;
    logic        table_full;
    logic        was_truncated;
    logic        entry_valid;
  } out_item_t;

  // Command passed from the word assembler to the table engine.
  typedef struct packed {
    logic              is_read;
    logic [TEXT_OUT-1:0] text;
    logic [LEN_W-1:0]  len;
    logic              trunc;
    logic [IDX_OUT-1:0] idx;
  } cmd_t;

  // Whitespace bytes: space, tab, newline, vertical tab, form feed, carriage return.
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

FILE: rtl/wft_queue.sv
module wft_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic [1:0]   count_r, count_nxt;
  logic         wr_ptr_r, rd_ptr_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = slot_r[rd_ptr_r];

  // Occupancy follows the accepted writes and reads.
  always_comb begin
    count_nxt = count_r;
    if ((wr_en && !full) && !(rd_en && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!(wr_en && !full) && (rd_en && !empty)) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (wr_en && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/wft_front.sv
module wft_front #(
  parameter int WORD_CHARS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  wft_pkg::in_item_t in_item,
  output logic              cmd_push,
  output wft_pkg::cmd_t     cmd_data
);

  localparam int LEN_W = wft_pkg::LEN_W;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(WORD_CHARS);

  logic [wft_pkg::TEXT_OUT-1:0] pend_text_r, pend_text_nxt;
  logic [LEN_W-1:0]             pend_len_r, pend_len_nxt;
  logic                         pend_trunc_r, pend_trunc_nxt;
  logic                         end_word;

  // Classify each accepted item and build the pending word.
  always_comb begin
    pend_text_nxt  = pend_text_r;
    pend_len_nxt   = pend_len_r;
    pend_trunc_nxt = pend_trunc_r;
    end_word       = 1'b0;
    cmd_push       = 1'b0;
    cmd_data       = '0;
    if (in_valid) begin
      unique case (in_item.req_type)
        wft_pkg::REQ_TEXT: begin
          if (wft_pkg::is_space(in_item.char_byte)) begin
            end_word = (pend_len_r != '0);
          end else if (pend_len_r < LEN_LIMIT) begin
            for (int k = 0; k < WORD_CHARS; k++) begin
              if (pend_len_r == LEN_W'(k)) begin
                pend_text_nxt[8*k +: 8] = in_item.char_byte;
              end
            end
            pend_len_nxt = pend_len_r + LEN_W'(1);
          end else begin
            pend_trunc_nxt = 1'b1;
          end
        end
        wft_pkg::REQ_FLUSH: begin
          end_word = (pend_len_r != '0);
        end
        wft_pkg::REQ_READ: begin
          cmd_push         = 1'b1;
          cmd_data.is_read = 1'b1;
          cmd_data.idx     = in_item.read_index;
        end
        default: begin
        end
      endcase
    end
    // A finished word goes to the engine and the pending word starts afresh.
    if (end_word) begin
      cmd_push       = 1'b1;
      cmd_data.text  = pend_text_r;
      cmd_data.len   = pend_len_r;
      cmd_data.trunc = pend_trunc_r;
      pend_text_nxt  = '0;
      pend_len_nxt   = '0;
      pend_trunc_nxt = 1'b0;
    end
  end

  // Pending word registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_text_r  <= '0;
      pend_len_r   <= '0;
      pend_trunc_r <= 1'b0;
    end else begin
      pend_text_r  <= pend_text_nxt;
      pend_len_r   <= pend_len_nxt;
      pend_trunc_r <= pend_trunc_nxt;
    end
  end

endmodule

FILE: rtl/wft_engine.sv
`include "word_frequency_table_core_defines.svh"

module wft_engine #(
  parameter int TABLE_DEPTH = 32,
  parameter int WORD_CHARS  = 8,
  parameter int COUNT_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wft_pkg::cmd_t      cmd_in,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output wft_pkg::out_item_t res
);

  localparam int LEN_W  = wft_pkg::LEN_W;
  localparam int TEXT_W = 8 * WORD_CHARS;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [USED_W-1:0]     USED_MAX = USED_W'(TABLE_DEPTH);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

  typedef struct packed {
    logic [TEXT_W-1:0]     text;
    logic [LEN_W-1:0]      len;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_READ} state_t;

  state_t            state_r, state_nxt;
  wft_pkg::cmd_t     cmd_r, cmd_nxt, cmd_cur;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [USED_W-1:0] used_r, used_nxt;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic              hit;
  logic              do_insert;
  logic              do_full;
  logic [COUNT_BITS-1:0] inc_count;

  // Clamp a stored count to the width of the result field.
  function automatic logic [wft_pkg::CNT_OUT-1:0] show_count(
    input logic [COUNT_BITS-1:0] c
  );
    logic [31:0] ext;
    ext = 32'(c);
    return (ext > wft_pkg::CNT_FIELD_MAX) ? wft_pkg::CNT_OUT'(wft_pkg::CNT_FIELD_MAX)
                                          : ext[wft_pkg::CNT_OUT-1:0];
  endfunction

  assign cmd_cur   = (state_r == ST_IDLE) ? cmd_in : cmd_r;
  assign hit       = (rd_data_r.len == cmd_r.len) && (rd_data_r.text == cmd_r.text[TEXT_W-1:0]);
  assign inc_count = (rd_data_r.count == CNT_MAX) ? rd_data_r.count
                                                  : rd_data_r.count + COUNT_BITS'(1);

  // Sequencer: one table entry is compared per cycle, in order of first appearance.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    scan_nxt  = scan_r;
    used_nxt  = used_r;
    cmd_pop   = 1'b0;
    rd_addr   = '0;
    we        = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    res_push  = 1'b0;
    res       = '0;
    do_insert = 1'b0;
    do_full   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_in;
          if (cmd_in.is_read) begin
            if (32'(cmd_in.idx) < 32'(used_r)) begin
              rd_addr   = IDX_W'(cmd_in.idx);
              state_nxt = ST_READ;
            end else begin
              res_push        = 1'b1;
              res.result_kind = wft_pkg::KIND_READ;
            end
          end else if (used_r == '0) begin
            do_insert = 1'b1;
          end else begin
            rd_addr   = '0;
            scan_nxt  = '0;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          we                = 1'b1;
          wr_addr           = scan_r;
          wr_data           = rd_data_r;
          wr_data.count     = inc_count;
          res_push          = 1'b1;
          res.result_kind   = wft_pkg::KIND_WORD;
          res.entry_index   = wft_pkg::IDX_OUT'(scan_r);
          res.word_text     = cmd_r.text;
          res.word_length   = cmd_r.len;
          res.word_count    = show_count(inc_count);
          res.was_truncated = cmd_r.trunc;
          state_nxt         = ST_IDLE;
        end else if (32'(scan_r) + 32'd1 < 32'(used_r)) begin
          scan_nxt = scan_r + IDX_W'(1);
          rd_addr  = scan_r + IDX_W'(1);
        end else begin
          do_full   = (used_r == USED_MAX);
          do_insert = !do_full;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        res_push        = 1'b1;
        res.result_kind = wft_pkg::KIND_READ;
        res.entry_index = cmd_r.idx;
        res.word_text   = wft_pkg::TEXT_OUT'(rd_data_r.text);
        res.word_length = rd_data_r.len;
        res.word_count  = show_count(rd_data_r.count);
        res.entry_valid = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A missed word takes the next free entry with a count of one.
    if (do_insert) begin
      we                = 1'b1;
      wr_addr           = IDX_W'(used_r);
      wr_data.text      = cmd_cur.text[TEXT_W-1:0];
      wr_data.len       = cmd_cur.len;
      wr_data.count     = COUNT_BITS'(1);
      used_nxt          = used_r + USED_W'(1);
      res_push          = 1'b1;
      res.result_kind   = wft_pkg::KIND_WORD;
      res.entry_index   = wft_pkg::IDX_OUT'(used_r);
      res.word_text     = cmd_cur.text;
      res.word_length   = cmd_cur.len;
      res.word_count    = wft_pkg::CNT_OUT'(1);
      res.is_new        = 1'b1;
      res.was_truncated = cmd_cur.trunc;
    end

    // A missed word with no free entry is reported and dropped.
    if (do_full) begin
      res_push          = 1'b1;
      res.result_kind   = wft_pkg::KIND_WORD;
      res.word_text     = cmd_r.text;
      res.word_length   = cmd_r.len;
      res.table_full    = 1'b1;
      res.was_truncated = cmd_r.trunc;
    end
  end

  // Sequencer state and table fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      scan_r  <= scan_nxt;
    end
  end

  // The command being worked on needs no reset.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  // Table memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  `WFT_ASSERT_ALWAYS(a_used_bound, 32'(used_r) <= TABLE_DEPTH, "table fill count beyond depth")
  `WFT_ASSERT_ALWAYS(a_no_overflow, !(res_push && res_full), "result pushed into full queue")
  `WFT_ASSERT_IMPLY(a_full_flag, res_push && res.table_full, used_r == USED_MAX,
                    "table full reported while entries are free")
  `WFT_ASSERT_IMPLY(a_scan_range, state_r == ST_SEARCH, 32'(scan_r) < 32'(used_r),
                    "search beyond filled entries")
  `WFT_ASSERT_NEXT(a_insert_grows, res_push && res.is_new,
                   used_r == $past(used_r) + USED_W'(1), "insert did not grow the table")

endmodule

FILE: rtl/word_frequency_table_core.sv
// Throughput: one item per cycle while full is low; a word end occupies the table engine
// until its match or miss is found, with one table memory read per compared entry.
// Synchronous active-low reset clears the pending word, the fill count and both queues.
module word_frequency_table_core #(
  parameter int TABLE_DEPTH = 32,
  parameter int WORD_CHARS  = 8,
  parameter int COUNT_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  wft_pkg::in_item_t   in_item,
  output logic                empty,
  input  logic                pop,
  output wft_pkg::out_item_t  out_item
);

  localparam int CMD_W = $bits(wft_pkg::cmd_t);
  localparam int OUT_W = $bits(wft_pkg::out_item_t);

  logic               cmd_push;
  wft_pkg::cmd_t      cmd_wdata;
  logic [CMD_W-1:0]   cmd_rdata;
  logic               cmd_full;
  logic               cmd_empty;
  logic               cmd_pop;
  logic               res_push;
  logic               res_full;
  wft_pkg::out_item_t res;
  logic [OUT_W-1:0]   out_raw;

  // Items are taken whenever the command queue has room.
  assign full = cmd_full;

  // Word assembler.
  wft_front #(
    .WORD_CHARS (WORD_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (push && !cmd_full),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wdata)
  );

  // Command queue between assembler and engine.
  wft_queue #(
    .W (CMD_W)
  ) u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wdata),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rdata),
    .empty   (cmd_empty)
  );

  // Table search and update engine.
  wft_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_CHARS  (WORD_CHARS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_in    (wft_pkg::cmd_t'(cmd_rdata)),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue towards the consumer.
  wft_queue #(
    .W (OUT_W)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_raw),
    .empty   (empty)
  );

  assign out_item = wft_pkg::out_item_t'(out_raw);

endmodule

FILE: tb/word_count_checker.sv
module word_count_checker
  import wft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_item,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_SLOTS   = 32;
  localparam int          CHAR_SLOTS    = 8;
  localparam logic [15:0] COUNT_CEILING = 16'hFFFF;

  // Word being assembled from text items.
  logic [63:0] word_buf;
  logic [3:0]  word_len;
  logic        word_trunc;

  // Shadow of the frequency table, in order of first appearance.
  logic [63:0] slot_text  [TABLE_SLOTS];
  logic [3:0]  slot_len   [TABLE_SLOTS];
  logic [15:0] slot_count [TABLE_SLOTS];
  int          slots_used;

  out_item_t   expected_reports[$];
  out_item_t   oldest;
  int          reports_seen;

  initial begin
    mismatch_count = 0;
    reports_due    = 0;
    reports_seen   = 0;
    slots_used     = 0;
    word_buf       = '0;
    word_len       = '0;
    word_trunc     = 1'b0;
  end

  // The six whitespace bytes split words; every other byte value is a character.
  function automatic logic is_separator(input logic [7:0] c);
    case (c)
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Closes the pending word: count a match, insert a miss or report a full table.
  function automatic void close_word();
    out_item_t rpt;
    int        hit;
    if (word_len == 0) return;
    rpt               = '0;
    rpt.result_kind   = KIND_WORD;
    rpt.word_text     = word_buf;
    rpt.word_length   = word_len;
    rpt.was_truncated = word_trunc;
    hit = -1;
    for (int i = 0; i < slots_used; i++) begin
      if (hit < 0 && slot_len[i] == word_len && slot_text[i] == word_buf) hit = i;
    end
    if (hit >= 0) begin
      if (slot_count[hit] != COUNT_CEILING) slot_count[hit]++;
      rpt.entry_index = 5'(hit);
      rpt.word_count  = slot_count[hit];
    end else if (slots_used >= TABLE_SLOTS) begin
      rpt.table_full = 1'b1;
    end else begin
      slot_text[slots_used]  = word_buf;
      slot_len[slots_used]   = word_len;
      slot_count[slots_used] = 16'd1;
      rpt.entry_index        = 5'(slots_used);
      rpt.word_count         = 16'd1;
      rpt.is_new             = 1'b1;
      slots_used++;
    end
    expected_reports.push_back(rpt);
    word_buf   = '0;
    word_len   = '0;
    word_trunc = 1'b0;
  endfunction

  // Works out what one accepted item does to the table and what it reports.
  function automatic void predict_item(input in_item_t it);
    out_item_t rpt;
    case (it.req_type)
      REQ_TEXT: begin
        if (is_separator(it.char_byte)) begin
          close_word();
        end else if (word_len < CHAR_SLOTS) begin
          word_buf[8*word_len +: 8] = it.char_byte;
          word_len++;
        end else begin
          word_trunc = 1'b1;
        end
      end
      REQ_FLUSH: close_word();
      REQ_READ: begin
        rpt             = '0;
        rpt.result_kind = KIND_READ;
        if (it.read_index < slots_used) begin
          rpt.entry_index = it.read_index;
          rpt.word_text   = slot_text[it.read_index];
          rpt.word_length = slot_len[it.read_index];
          rpt.word_count  = slot_count[it.read_index];
          rpt.entry_valid = 1'b1;
        end
        expected_reports.push_back(rpt);
      end
      default: ;
    endcase
  endfunction

  // Prints one line for each failure and counts it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
             reports_seen, what, got, want);
  endtask

  task automatic compare_report(input out_item_t got, input out_item_t want);
    if (got.result_kind !== want.result_kind)
      report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
    if (got.entry_index !== want.entry_index)
      report_mismatch("entry_index", 64'(got.entry_index), 64'(want.entry_index));
    if (got.word_text !== want.word_text)
      report_mismatch("word_text", got.word_text, want.word_text);
    if (got.word_length !== want.word_length)
      report_mismatch("word_length", 64'(got.word_length), 64'(want.word_length));
    if (got.word_count !== want.word_count)
      report_mismatch("word_count", 64'(got.word_count), 64'(want.word_count));
    if (got.is_new !== want.is_new)
      report_mismatch("is_new", 64'(got.is_new), 64'(want.is_new));
    if (got.table_full !== want.table_full)
      report_mismatch("table_full", 64'(got.table_full), 64'(want.table_full));
    if (got.was_truncated !== want.was_truncated)
      report_mismatch("was_truncated", 64'(got.was_truncated), 64'(want.was_truncated));
    if (got.entry_valid !== want.entry_valid)
      report_mismatch("entry_valid", 64'(got.entry_valid), 64'(want.entry_valid));
  endtask

  // Both channels are sampled at the rising edge, as the block sees them.
  always @(posedge clk) begin
    if (!rst_n) begin
      word_buf   = '0;
      word_len   = '0;
      word_trunc = 1'b0;
      slots_used = 0;
      expected_reports.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with nothing expected, word_text", out_item.word_text, '0);
        end else begin
          oldest = expected_reports.pop_front();
          compare_report(out_item, oldest);
        end
        reports_seen++;
      end
      if (push && !full) predict_item(in_item);
    end
    reports_due = expected_reports.size();
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wft_pkg::*;

  localparam logic [1:0] REQ_UNUSED      = 2'd3;
  localparam int         CYCLE_LIMIT     = 2_000_000;
  localparam int         DRAIN_CYCLES    = 64;
  localparam int         ITEMS_PER_PHASE = 230;
  localparam int         REPEAT_WORDS    = 24;
  localparam int         VOCAB_SIZE      = 40;
  localparam int         VOCAB_MAX_LEN   = 12;
  localparam int         STORED_CHARS    = 8;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_item_t    in_item;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;

  int          mismatch_count;
  int          reports_due;
  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;
  int          items_sent    = 0;
  int unsigned cycle_count   = 0;

  logic [7:0]  separators [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  logic [7:0]  vocab_chars [VOCAB_SIZE][VOCAB_MAX_LEN];
  int          vocab_len   [VOCAB_SIZE];

  word_frequency_table_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  word_count_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_item        (in_item),
    .empty          (empty),
    .pop            (pop),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .reports_due    (reports_due)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Run limit against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: pop at the falling edge, stalling at the current rate.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Offers one item from a falling edge and returns at the falling edge after it
  // is taken. The valid is left high so that a following item can go straight on.
  task automatic send_item(input in_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (it.req_type != REQ_UNUSED) items_sent++;
  endtask

  task automatic send_text(input logic [7:0] c);
    in_item_t it;
    it.req_type   = REQ_TEXT;
    it.char_byte  = c;
    it.read_index = 5'($urandom_range(31));
    send_item(it);
  endtask

  // Requests other than text carry a random byte that the block must ignore.
  task automatic send_request(input logic [1:0] req, input logic [4:0] idx);
    in_item_t it;
    it.req_type   = req;
    it.char_byte  = 8'($urandom_range(255));
    it.read_index = idx;
    send_item(it);
  endtask

  function automatic logic [7:0] random_word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
    return c;
  endfunction

  // Vocabulary larger than the table, with shared prefixes so that truncated
  // words collide and shorter prefixes miss.
  task automatic build_vocabulary();
    int pick;
    for (int k = 0; k < VOCAB_SIZE; k++) begin
      pick = $urandom_range(3);
      if (k > 0 && pick == 0 && vocab_len[k-1] > STORED_CHARS) begin
        vocab_len[k] = $urandom_range(STORED_CHARS + 1, VOCAB_MAX_LEN);
        for (int j = 0; j < VOCAB_MAX_LEN; j++)
          vocab_chars[k][j] = (j < STORED_CHARS) ? vocab_chars[k-1][j] : random_word_char();
      end else if (k > 0 && pick == 1) begin
        vocab_len[k] = $urandom_range(1, vocab_len[k-1]);
        for (int j = 0; j < VOCAB_MAX_LEN; j++) vocab_chars[k][j] = vocab_chars[k-1][j];
      end else begin
        vocab_len[k] = $urandom_range(1, VOCAB_MAX_LEN);
        for (int j = 0; j < VOCAB_MAX_LEN; j++) vocab_chars[k][j] = random_word_char();
      end
    end
  endtask

  // A vocabulary word ended mostly by whitespace, sometimes by a flush or a run of blanks.
  task automatic send_vocab_word();
    int k;
    int ending;
    k      = $urandom_range(VOCAB_SIZE - 1);
    ending = $urandom_range(99);
    for (int j = 0; j < vocab_len[k]; j++) send_text(vocab_chars[k][j]);
    if (ending < 80) begin
      send_text(separators[$urandom_range(5)]);
    end else if (ending < 92) begin
      send_request(REQ_FLUSH, 5'($urandom_range(31)));
    end else begin
      repeat ($urandom_range(2, 4)) send_text(separators[$urandom_range(5)]);
    end
  endtask

  // Mostly whole words, with reads, stray bytes, unused requests and flushes between.
  task automatic random_phase(input int idle_pct, input int stall_pct);
    int start;
    int pick;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    start         = items_sent;
    while (items_sent - start < ITEMS_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 70) send_vocab_word();
      else if (pick < 80) send_request(REQ_READ, 5'($urandom_range(31)));
      else if (pick < 90) send_text(8'($urandom_range(255)));
      else if (pick < 95) send_request(REQ_UNUSED, 5'($urandom_range(31)));
      else send_request(REQ_FLUSH, 5'($urandom_range(31)));
    end
  endtask

  initial begin
    logic [7:0] rep_char;
    rst_n   = 1'b0;
    push    = 1'b0;
    in_item = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table: a read of an unfilled entry, a flush and a blank with nothing
    // pending, and the unused request code.
    send_request(REQ_READ, 5'd0);
    send_request(REQ_FLUSH, 5'd31);
    send_text(8'h20);
    send_request(REQ_UNUSED, 5'd31);

    // One single-character word repeated several times, cycling through all six
    // whitespace bytes as terminators.
    rep_char = random_word_char();
    for (int n = 0; n < REPEAT_WORDS; n++) begin
      send_text(rep_char);
      send_text(separators[n % 6]);
    end
    send_request(REQ_READ, 5'd0);

    // A zero byte is a character; a flush ends the pending word.
    send_text(8'h00);
    send_request(REQ_FLUSH, 5'd0);

    // A word of exactly the stored length, all ones.
    repeat (STORED_CHARS) send_text(8'hFF);
    send_text(8'h09);

    // A word one character too long, with a read and an unused request inside it.
    send_text(8'h01);
    send_text(8'h02);
    send_text(8'h04);
    send_request(REQ_READ, 5'd2);
    send_text(8'h08);
    send_text(8'h10);
    send_request(REQ_UNUSED, 5'd0);
    send_text(8'h40);
    send_text(8'h80);
    send_text(8'h7F);
    send_text(8'hAA);
    send_text(8'h0D);
    send_request(REQ_READ, 5'd31);
    send_request(REQ_READ, 5'd3);

    // Random traffic under each idling pattern.
    build_vocabulary();
    random_phase(0, 0);
    random_phase(58, 0);
    random_phase(0, 58);
    random_phase(18, 18);

    // Close any pending word, then let every result drain.
    send_request(REQ_FLUSH, 5'd0);
    push          <= 1'b0;
    pop_stall_pct  = 0;
    while (reports_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/wft_pkg.sv
rtl/wft_queue.sv
rtl/wft_front.sv
rtl/wft_engine.sv
rtl/word_frequency_table_core.sv
tb/word_count_checker.sv
tb/tb_top.sv
